[hdl/sts_pkg.sv]
// shared types and constants of the sorted table search block
// no dependencies
`timescale 1ns / 1ps

package sts_pkg;

  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_RESULT
  } state_t;

endpackage

[hdl/sts_stream_if.sv]
// valid/ready channel carrying one item of a given payload type
// payload types come from sts_pkg
`timescale 1ns / 1ps

interface sts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/sts_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sorted_table_binary_search.sv]
// top level: sorted table of signed values with write and binary search commands
// depends on sts_pkg, sts_stream_if and sts_ram
`timescale 1ns / 1ps

// Holds a table of signed 32-bit values, kept sorted ascending by the user, in
// one synchronous ram. A write item stores item_value at entry_index (indexes at
// or above TABLE_DEPTH are dropped) and gives no result. A search item runs a
// binary search for item_value over entries 0 to table_count-1 (count saturated
// at TABLE_DEPTH) and gives one result item: found and match_index, with
// match_index 0 when nothing matched. The search issues its first ram read in
// the accept cycle, then does one probe per cycle on the single ram read port.
// One item is handled at a time; the next item is taken while the last result
// still sits in the output register. table_count is written through
// cfg_we/cfg_data; the user must write it only while the block is idle, and the
// block itself does not enforce it. Table entries below the count must be
// written before a search reads them; the ram has no reset.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sts_pkg::COUNT_W-1:0] cfg_data,
  sts_stream_if.sink                  req,
  sts_stream_if.source                rsp
);
  import sts_pkg::*;

  // widths that follow from the table depth
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW     = (ADDR_W > COUNT_W) ? ADDR_W : COUNT_W;
  localparam logic [PW:0] DEPTH_V = (PW + 1)'(TABLE_DEPTH);

  // configuration
  logic [COUNT_W-1:0] table_count;

  // search state: the live range is [low, hi), mid is the entry being read
  state_t                    state, state_next;
  logic [COUNT_W-1:0]        low, hi, mid;
  logic signed [VALUE_W-1:0] key;
  logic                      res_found;
  logic [INDEX_W-1:0]        res_index;

  // ram port
  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic signed [VALUE_W-1:0] ram_rdata;

  // combinational helpers
  logic               req_take, take_search, take_write;
  logic [PW:0]        count_wide, idx_wide;
  logic [COUNT_W-1:0] n_eff, mid_first;
  logic               probe_hit, probe_less;
  logic [COUNT_W-1:0] low_next, hi_next, mid_next, rd_pos;
  logic               range_empty;
  logic [PW-1:0]      rd_pos_wide;
  logic               out_free;

  assign req_take    = req.valid && req.ready;
  assign take_search = req_take && (req.data.command == CMD_SEARCH);
  assign take_write  = req_take && (req.data.command == CMD_WRITE);
  assign out_free    = !rsp.valid || rsp.ready;

  // effective count: saturate at the table depth
  assign count_wide = (PW + 1)'(table_count);
  assign n_eff      = (count_wide < DEPTH_V) ? table_count : DEPTH_V[COUNT_W-1:0];
  assign mid_first  = (n_eff - COUNT_W'(1)) >> 1;

  // probe step: compare the word read for mid and narrow the range
  assign probe_hit  = (ram_rdata == key);
  assign probe_less = (ram_rdata < key);
  assign low_next   = probe_less ? (mid + COUNT_W'(1)) : low;
  assign hi_next    = probe_less ? hi : mid;
  assign range_empty = (low_next >= hi_next);
  // same midpoint as low + (high - low) / 2 with high = hi - 1
  assign mid_next   = low_next + ((hi_next - low_next - COUNT_W'(1)) >> 1);

  // read address: first midpoint at accept, next midpoint while probing
  assign rd_pos      = (state == ST_IDLE) ? mid_first : mid_next;
  assign rd_pos_wide = PW'(rd_pos);
  assign ram_raddr   = rd_pos_wide[ADDR_W-1:0];

  // write address, dropped when beyond the table
  assign idx_wide  = (PW + 1)'(req.data.entry_index);
  assign ram_waddr = idx_wide[ADDR_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_search) begin
          state_next = (n_eff == '0) ? ST_RESULT : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_hit || range_empty) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        ram_we    = take_write && (idx_wide < DEPTH_V);
        ram_re    = take_search && (n_eff != '0);
      end
      ST_PROBE: begin
        ram_re = !probe_hit && !range_empty;
      end
      ST_RESULT: begin
        req.ready = 1'b0;
      end
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
    end else if (cfg_we) begin
      table_count <= cfg_data;
    end
  end

  // search datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (take_search) begin
          key       <= req.data.item_value;
          low       <= '0;
          hi        <= n_eff;
          mid       <= mid_first;
          res_found <= 1'b0;
          res_index <= '0;
        end
      end
      ST_PROBE: begin
        low <= low_next;
        hi  <= hi_next;
        mid <= mid_next;
        if (probe_hit) begin
          res_found <= 1'b1;
          res_index <= mid[INDEX_W-1:0];
        end
      end
      ST_RESULT: begin
        res_found <= res_found;
      end
      default: res_found <= res_found;
    endcase
  end

  // output register, free to take a new result once the old one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == ST_RESULT) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      rsp.data.found       <= res_found;
      rsp.data.match_index <= res_index;
    end
  end

  sts_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.data.item_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a probe always has a non-empty range behind it
  a_probe_range : assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (low < hi))
    else $error("probe with empty search range");

  // a miss always reports index zero
  a_miss_index : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.data.found) |-> (rsp.data.match_index == '0))
    else $error("miss result with nonzero index");

  // a write item never starts a search
  a_write_idle : assert property (@(posedge clk) disable iff (rst)
    take_write |=> (state == ST_IDLE))
    else $error("write item left idle state");

  // a search item always leaves idle
  a_search_busy : assert property (@(posedge clk) disable iff (rst)
    take_search |=> (state != ST_IDLE))
    else $error("search item did not start");

endmodule
